// ===== rtl/rsa_mexp_pkg.sv =====
// Shared types and constants of the RSA modular exponentiation block.
package rsa_mexp_pkg;

   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODULUS          = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PUBLIC_EXPONENT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRIVATE_EXPONENT = 2'd2;

   localparam logic FUNC_ENCRYPT = 1'b0;
   localparam logic FUNC_DECRYPT = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

endpackage

// ===== rtl/rsa_mexp_modmul.sv =====
// Iterative shift-and-add modular multiplier with one shared modular adder.
module rsa_mexp_modmul
   import rsa_mexp_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WIDTH-1:0]     op_a,
   input  logic [WIDTH-1:0]     op_b,
   input  logic [WIDTH-1:0]     modulus,
   output logic [WIDTH-1:0]     product,
   output mul_status_type       status
);

   localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH-1:0] r_ff, r_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             phase_ff, phase_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [WIDTH-1:0] addend;
   logic [WIDTH:0]   sum_w;
   logic [WIDTH:0]   diff_w;
   logic [WIDTH-1:0] mod_sum;

   // With the modulus at zero the sum simply wraps at the word width.
   always_comb begin
      addend  = phase_ff ? a_ff : r_ff;
      sum_w   = {1'b0, r_ff} + {1'b0, addend};
      diff_w  = sum_w - {1'b0, modulus};
      if ((modulus != '0) && (sum_w >= {1'b0, modulus})) begin
         mod_sum = diff_w[WIDTH-1:0];
      end else begin
         mod_sum = sum_w[WIDTH-1:0];
      end
   end

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      r_in     = r_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         a_in     = op_a;
         b_in     = op_b;
         r_in     = '0;
         cnt_in   = CNT_W'(WIDTH - 1);
         phase_in = 1'b0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         r_in = mod_sum;
         if (!phase_ff && b_ff[WIDTH-1]) begin
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            b_in     = {b_ff[WIDTH-2:0], 1'b0};
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      r_ff     <= r_in;
      cnt_ff   <= cnt_in;
      phase_ff <= phase_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign product     = r_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== rtl/rsa_modular_exponentiation.sv =====
// Top level of the RSA modular exponentiation block: registers, sequencer and output stage.
// One request raises its value to the public exponent (encrypt) or the private exponent
// (decrypt) modulo the configured modulus, least significant exponent bit first, and gives
// one result; an exponent of zero gives 1, a nonzero exponent with a modulus of one gives 0,
// and a modulus of zero makes all products wrap at WIDTH bits. Every multiplication,
// including the initial reduction of the value, runs on one shift-and-add modular
// multiplier that doubles once per multiplier bit and adds the multiplicand for each set
// multiplier bit. A request costs one reduction, then for every exponent bit up to the
// highest set one a squaring, plus one multiplication per set exponent bit (the squaring
// after the highest set bit is skipped). The block takes no new request while one is in
// progress; a finished result waits in the output register.
module rsa_modular_exponentiation
   import rsa_mexp_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_func,
   input  logic [WIDTH-1:0]       req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [WIDTH-1:0]       rsp_result,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WIDTH-1:0]       csr_wdata
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_REDUCE = 3'd1;
   localparam logic [2:0] S_EXP    = 3'd2;
   localparam logic [2:0] S_MULACC = 3'd3;
   localparam logic [2:0] S_SQR    = 3'd4;
   localparam logic [2:0] S_OUT    = 3'd5;

   logic [WIDTH-1:0] modulus_ff, modulus_in;
   logic [WIDTH-1:0] pub_exp_ff, pub_exp_in;
   logic [WIDTH-1:0] priv_exp_ff, priv_exp_in;
   logic [2:0]       state_ff, state_in;
   logic [WIDTH-1:0] ex_ff, ex_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] base_ff, base_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0] rsp_result_ff, rsp_result_in;

   logic             mul_start;
   logic [WIDTH-1:0] mul_a;
   logic [WIDTH-1:0] mul_b;
   logic [WIDTH-1:0] mul_product;
   mul_status_type   mul_status;

   logic             rsp_free;
   logic [WIDTH-1:0] sel_exp;
   logic             mod_is_one;

   rsa_mexp_modmul #(
      .WIDTH (WIDTH)
   ) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (modulus_ff),
      .product (mul_product),
      .status  (mul_status)
   );

   always_comb begin
      modulus_in  = modulus_ff;
      pub_exp_in  = pub_exp_ff;
      priv_exp_in = priv_exp_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MODULUS:          modulus_in  = csr_wdata;
            CSR_PUBLIC_EXPONENT:  pub_exp_in  = csr_wdata;
            CSR_PRIVATE_EXPONENT: priv_exp_in = csr_wdata;
            default:              modulus_in  = modulus_ff;
         endcase
      end
   end

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign sel_exp    = (req_func == FUNC_DECRYPT) ? priv_exp_ff : pub_exp_ff;
   assign mod_is_one = (modulus_ff == WIDTH'(1));

   always_comb begin
      state_in      = state_ff;
      ex_in         = ex_ff;
      acc_in        = acc_ff;
      base_in       = base_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_result_in = rsp_result_ff;
      mul_start     = 1'b0;
      mul_a         = acc_ff;
      mul_b         = base_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ex_in = sel_exp;
               if (sel_exp == '0) begin
                  acc_in   = WIDTH'(1);
                  state_in = S_OUT;
               end else if (mod_is_one) begin
                  acc_in   = '0;
                  state_in = S_OUT;
               end else begin
                  acc_in    = WIDTH'(1);
                  mul_start = 1'b1;
                  mul_a     = WIDTH'(1);
                  mul_b     = req_value;
                  state_in  = S_REDUCE;
               end
            end
         end
         S_REDUCE: begin
            if (mul_status.done) begin
               base_in  = mul_product;
               state_in = S_EXP;
            end
         end
         S_EXP: begin
            if (ex_ff == '0) begin
               state_in = S_OUT;
            end else if (ex_ff[0]) begin
               mul_start = 1'b1;
               mul_a     = acc_ff;
               mul_b     = base_ff;
               state_in  = S_MULACC;
            end else begin
               mul_start = 1'b1;
               mul_a     = base_ff;
               mul_b     = base_ff;
               state_in  = S_SQR;
            end
         end
         S_MULACC: begin
            if (mul_status.done) begin
               acc_in   = mul_product;
               ex_in    = {ex_ff[WIDTH-1:1], 1'b0};
               state_in = S_EXP;
            end
         end
         S_SQR: begin
            if (mul_status.done) begin
               base_in  = mul_product;
               ex_in    = {1'b0, ex_ff[WIDTH-1:1]};
               state_in = S_EXP;
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = acc_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ex_ff         <= ex_in;
      acc_ff        <= acc_in;
      base_ff       <= base_in;
      rsp_result_ff <= rsp_result_in;
      if (reset) begin
         modulus_ff   <= WIDTH'(2);
         pub_exp_ff   <= WIDTH'(1);
         priv_exp_ff  <= WIDTH'(1);
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         pub_exp_ff   <= pub_exp_in;
         priv_exp_ff  <= priv_exp_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   // The multiplier is never restarted while it is still working.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_status.busy)
      else $error("multiplier started while busy");

   // A finished multiplication is only ever seen while the sequencer waits for one.
   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      mul_status.done |->
         (state_ff == S_REDUCE || state_ff == S_MULACC || state_ff == S_SQR))
      else $error("multiplier result arrived with nobody waiting");

   // An exhausted exponent always leads straight to the output stage.
   a_exp_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXP && ex_ff == '0) |=> (state_ff == S_OUT))
      else $error("exponent exhausted but no result produced");

   // A request that is taken always starts work.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("request accepted but sequencer stayed idle");

endmodule
